>>> hw/rtl/srle_pkg.sv
package srle_pkg;

    localparam int PAT_W       = 6;
    localparam int LEN_W       = 13;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIGITS      = 4;
    localparam int DIG_IDX_W   = $clog2(DIGITS);
    localparam int NDIG_W      = $clog2(DIGITS + 1);
    localparam int THR_W       = 3;

    localparam logic [CHAR_W-1:0] CHAR_BASE   = 7'd63;
    localparam logic [CHAR_W-1:0] REPEAT_MARK = 7'd33;
    localparam logic [CHAR_W-1:0] DIGIT_BASE  = 7'd48;
    localparam logic [THR_W-1:0]  LITERAL_BUDGET = 3'd7;
    localparam logic [7:0]        MIN_RUN_RESET  = 8'd4;

    // floor(v / 10) = (v * RECIP_TEN) >> 16 for v below 16384
    localparam logic [13:0] RECIP_TEN = 14'd6554;

    typedef struct packed {
        logic             old_v;
        logic [PAT_W-1:0] old_pat;
        logic [LEN_W-1:0] old_len;
        logic             fin_v;
        logic [PAT_W-1:0] fin_pat;
        logic [LEN_W-1:0] fin_len;
        logic             last;
    } cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_MARK  = 6'b000100,
        ST_DIGIT = 6'b001000,
        ST_CHAR  = 6'b010000,
        ST_EMPTY = 6'b100000
    } back_state_t;

endpackage

>>> hw/rtl/sixel_row_run_length_encoder_unit.sv
// Channel  Direction  Handshake          Word
// s_       in         s_valid/s_ready    s_column_mask[5:0], s_last_column
// m_       out        m_valid/m_ready    m_out_char[6:0], m_char_valid, m_row_end
// cfg_     in         cfg_wr_en          cfg_wr_data[7:0] (min_repeat_run)
//
// Input: one word per cycle while the 4-entry command queue has room.
// Output: one character per cycle while m_ready is high; a repeat run's count first
// runs through the divide-by-ten unit digit by digit; an idle back end pops in ST_IDLE.
// Reset: aresetn, synchronous; clears run state, queue and output valid flag.
// m_ready low holds the output register; the queue absorbs input meanwhile.
module sixel_row_run_length_encoder_unit #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [5:0] s_column_mask,
    input  logic       s_last_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_char_valid,
    output logic       m_row_end
);

    logic [7:0]     min_repeat_run_reg, min_repeat_run_next;
    logic           q_push, q_full, q_pop, q_empty;
    srle_pkg::cmd_t push_cmd, pop_cmd;

    assign min_repeat_run_next = cfg_wr_en ? cfg_wr_data : min_repeat_run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_repeat_run_reg <= srle_pkg::MIN_RUN_RESET;
        end else begin
            min_repeat_run_reg <= min_repeat_run_next;
        end
    end

    srle_front #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_column_mask (s_column_mask),
        .s_last_column (s_last_column),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    srle_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    srle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_run      (min_repeat_run_reg),
        .q_empty      (q_empty),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_row_end    (m_row_end)
    );

endmodule

>>> hw/rtl/srle_front.sv
module srle_front #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [srle_pkg::PAT_W-1:0] s_column_mask,
    input  logic                      s_last_column,
    input  logic                      q_full,
    output logic                      q_push,
    output srle_pkg::cmd_t            q_cmd
);

    logic [srle_pkg::PAT_W-1:0] run_pattern_reg, run_pattern_next;
    logic [srle_pkg::LEN_W-1:0] run_length_reg, run_length_next;
    logic                       run_open_reg, run_open_next;

    logic                       accept;
    logic                       extend;
    logic [srle_pkg::PAT_W-1:0] cur_pat;
    logic [srle_pkg::LEN_W-1:0] cur_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    assign extend = run_open_reg && (s_column_mask == run_pattern_reg)
                    && (run_length_reg < srle_pkg::LEN_W'(MAX_COLUMNS));

    always_comb begin
        if (extend) begin
            cur_pat = run_pattern_reg;
            cur_len = run_length_reg + srle_pkg::LEN_W'(1);
        end else begin
            cur_pat = s_column_mask;
            cur_len = srle_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        q_cmd.old_v   = run_open_reg && !extend;
        q_cmd.old_pat = run_pattern_reg;
        q_cmd.old_len = run_length_reg;
        q_cmd.fin_v   = s_last_column && (cur_pat != '0);
        q_cmd.fin_pat = cur_pat;
        q_cmd.fin_len = cur_len;
        q_cmd.last    = s_last_column;
    end

    assign q_push = accept && (q_cmd.old_v || s_last_column);

    always_comb begin
        run_pattern_next = run_pattern_reg;
        run_length_next  = run_length_reg;
        run_open_next    = run_open_reg;
        if (accept) begin
            if (s_last_column) begin
                run_pattern_next = '0;
                run_length_next  = '0;
                run_open_next    = 1'b0;
            end else begin
                run_pattern_next = cur_pat;
                run_length_next  = cur_len;
                run_open_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_pattern_reg <= '0;
            run_length_reg  <= '0;
            run_open_reg    <= 1'b0;
        end else begin
            run_pattern_reg <= run_pattern_next;
            run_length_reg  <= run_length_next;
            run_open_reg    <= run_open_next;
        end
    end

endmodule

>>> hw/rtl/srle_fifo.sv
module srle_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  srle_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output srle_pkg::cmd_t pop_cmd,
    output logic           empty
);

    srle_pkg::cmd_t entry_reg [srle_pkg::QUEUE_DEPTH];

    logic [srle_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [srle_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [srle_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    assign full    = (count_reg == srle_pkg::QCNT_W'(srle_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + srle_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + srle_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + srle_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - srle_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/srle_back.sv
module srle_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [7:0]                  min_run,
    input  logic                        q_empty,
    input  srle_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [srle_pkg::CHAR_W-1:0] m_out_char,
    output logic                        m_char_valid,
    output logic                        m_row_end
);

    srle_pkg::back_state_t state_reg, state_next;

    logic [srle_pkg::PAT_W-1:0]  pat_reg, pat_next;
    logic [srle_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [srle_pkg::LEN_W-1:0]  div_reg, div_next;
    logic [3:0]                  dig_reg [srle_pkg::DIGITS];
    logic [3:0]                  dig_next [srle_pkg::DIGITS];
    logic [srle_pkg::NDIG_W-1:0] ndig_reg, ndig_next;
    logic                        sec_v_reg, sec_v_next;
    logic [srle_pkg::PAT_W-1:0]  sec_pat_reg, sec_pat_next;
    logic [srle_pkg::LEN_W-1:0]  sec_len_reg, sec_len_next;
    logic                        last_reg, last_next;

    logic                        m_valid_reg, m_valid_next;
    logic [srle_pkg::CHAR_W-1:0] out_char_reg;
    logic                        char_valid_reg, row_end_reg;

    logic [srle_pkg::THR_W-1:0]  thr;
    logic                        slot_free;
    logic                        fetch;
    logic                        emit;
    logic [srle_pkg::CHAR_W-1:0] e_char;
    logic                        e_cv, e_end;
    logic                        seg_go;
    logic [srle_pkg::PAT_W-1:0]  seg_pat;
    logic [srle_pkg::LEN_W-1:0]  seg_len;
    logic [26:0]                 prod;
    logic [9:0]                  quot;
    logic [13:0]                 quot_x10;
    logic [3:0]                  rem;
    logic [srle_pkg::DIG_IDX_W-1:0] dig_idx;

    assign thr = (min_run > 8'(srle_pkg::LITERAL_BUDGET)) ? srle_pkg::LITERAL_BUDGET
                                                          : min_run[srle_pkg::THR_W-1:0];
    assign slot_free = !m_valid_reg || m_ready;

    // divide by ten, one digit per cycle
    assign prod     = {1'b0, div_reg} * srle_pkg::RECIP_TEN;
    assign quot     = prod[25:16];
    assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem      = 4'(14'({1'b0, div_reg}) - quot_x10);
    assign dig_idx  = srle_pkg::DIG_IDX_W'(ndig_reg - srle_pkg::NDIG_W'(1));

    always_comb begin
        state_next   = state_reg;
        pat_next     = pat_reg;
        len_next     = len_reg;
        div_next     = div_reg;
        dig_next     = dig_reg;
        ndig_next    = ndig_reg;
        sec_v_next   = sec_v_reg;
        sec_pat_next = sec_pat_reg;
        sec_len_next = sec_len_reg;
        last_next    = last_reg;
        fetch        = 1'b0;
        emit         = 1'b0;
        e_char       = '0;
        e_cv         = 1'b0;
        e_end        = 1'b0;
        seg_go       = 1'b0;
        seg_pat      = sec_pat_reg;
        seg_len      = sec_len_reg;
        q_pop        = 1'b0;

        case (state_reg)
            srle_pkg::ST_IDLE: begin
                fetch = 1'b1;
            end
            srle_pkg::ST_CONV: begin
                div_next = srle_pkg::LEN_W'(quot);
                dig_next[srle_pkg::DIG_IDX_W'(ndig_reg)] = rem;
                ndig_next = ndig_reg + srle_pkg::NDIG_W'(1);
                if (quot == '0) begin
                    state_next = srle_pkg::ST_MARK;
                end
            end
            srle_pkg::ST_MARK: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    e_char     = srle_pkg::REPEAT_MARK;
                    e_cv       = 1'b1;
                    state_next = srle_pkg::ST_DIGIT;
                end
            end
            srle_pkg::ST_DIGIT: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    e_char    = srle_pkg::DIGIT_BASE + srle_pkg::CHAR_W'(dig_reg[dig_idx]);
                    e_cv      = 1'b1;
                    ndig_next = ndig_reg - srle_pkg::NDIG_W'(1);
                    if (ndig_reg == srle_pkg::NDIG_W'(1)) begin
                        state_next = srle_pkg::ST_CHAR;
                        len_next   = srle_pkg::LEN_W'(1);
                    end
                end
            end
            srle_pkg::ST_CHAR: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_char   = srle_pkg::CHAR_BASE + srle_pkg::CHAR_W'(pat_reg);
                    e_cv     = 1'b1;
                    len_next = len_reg - srle_pkg::LEN_W'(1);
                    if (len_reg == srle_pkg::LEN_W'(1)) begin
                        e_end = last_reg && !sec_v_reg;
                        if (sec_v_reg) begin
                            seg_go     = 1'b1;
                            sec_v_next = 1'b0;
                        end else begin
                            fetch = 1'b1;
                        end
                    end
                end
            end
            srle_pkg::ST_EMPTY: begin
                if (slot_free) begin
                    emit  = 1'b1;
                    e_end = 1'b1;
                    fetch = 1'b1;
                end
            end
            default: begin
                state_next = srle_pkg::ST_IDLE;
            end
        endcase

        if (fetch) begin
            state_next = srle_pkg::ST_IDLE;
            if (!q_empty) begin
                q_pop        = 1'b1;
                last_next    = q_cmd.last;
                sec_pat_next = q_cmd.fin_pat;
                sec_len_next = q_cmd.fin_len;
                if (q_cmd.old_v) begin
                    seg_go     = 1'b1;
                    seg_pat    = q_cmd.old_pat;
                    seg_len    = q_cmd.old_len;
                    sec_v_next = q_cmd.fin_v;
                end else if (q_cmd.fin_v) begin
                    seg_go     = 1'b1;
                    seg_pat    = q_cmd.fin_pat;
                    seg_len    = q_cmd.fin_len;
                    sec_v_next = 1'b0;
                end else begin
                    sec_v_next = 1'b0;
                    state_next = srle_pkg::ST_EMPTY;
                end
            end
        end

        if (seg_go) begin
            pat_next = seg_pat;
            if (seg_len >= srle_pkg::LEN_W'(thr)) begin
                state_next = srle_pkg::ST_CONV;
                div_next   = seg_len;
                ndig_next  = '0;
            end else begin
                state_next = srle_pkg::ST_CHAR;
                len_next   = seg_len;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srle_pkg::ST_IDLE;
            sec_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sec_v_reg   <= sec_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg     <= pat_next;
        len_reg     <= len_next;
        div_reg     <= div_next;
        dig_reg     <= dig_next;
        ndig_reg    <= ndig_next;
        sec_pat_reg <= sec_pat_next;
        sec_len_reg <= sec_len_next;
        last_reg    <= last_next;
        if (emit) begin
            out_char_reg   <= e_char;
            char_valid_reg <= e_cv;
            row_end_reg    <= e_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_char   = out_char_reg;
    assign m_char_valid = char_valid_reg;
    assign m_row_end    = row_end_reg;

endmodule

>>> verif/srle_checker.sv
`timescale 1ns / 1ps

module srle_checker #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [5:0] s_column_mask,
    input  logic       s_last_column,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_out_char,
    input  logic       m_char_valid,
    input  logic       m_row_end,
    output int         fail_count,
    output int         chars_pending
);

    localparam logic [6:0] SIXEL_OFFSET = 7'd63;
    localparam logic [6:0] REPEAT_CHAR  = 7'd33;
    localparam logic [6:0] ZERO_CHAR    = 7'd48;
    localparam int         LONGEST_LITERAL = 7;
    localparam logic [7:0] THRESHOLD_AT_RESET = 8'd4;

    typedef struct packed {
        logic [6:0] ch;
        logic       has_char;
        logic       row_end;
    } sixel_word_t;

    sixel_word_t sixel_chars[$];

    logic [7:0]  repeat_threshold;
    logic [5:0]  run_pat;
    logic [12:0] run_len;
    logic        run_active;
    int          errors;

    function automatic void append_word(sixel_word_t w);
        sixel_chars.insert(sixel_chars.size(), w);
    endfunction

    function automatic void push_char(logic [6:0] c);
        sixel_word_t w;
        w.ch       = c;
        w.has_char = 1'b1;
        w.row_end  = 1'b0;
        append_word(w);
    endfunction

    function automatic int encode_run(logic [5:0] pat, logic [12:0] len);
        int         thr;
        int         nd;
        int         v;
        int         dg[5];
        logic [6:0] c;
        c = SIXEL_OFFSET + {1'b0, pat};
        if (len == 0) return 0;
        thr = (repeat_threshold > LONGEST_LITERAL) ? LONGEST_LITERAL : int'(repeat_threshold);
        if (int'(len) >= thr) begin
            v  = int'(len);
            nd = 0;
            do begin
                dg[nd] = v % 10;
                nd++;
                v = v / 10;
            end while (v != 0 && nd < 5);
            push_char(REPEAT_CHAR);
            for (int i = nd - 1; i >= 0; i--) push_char(ZERO_CHAR + 7'(dg[i]));
            push_char(c);
            return nd + 2;
        end
        for (int i = 0; i < int'(len); i++) push_char(c);
        return int'(len);
    endfunction

    function automatic void encode_column(logic [5:0] mask, logic last);
        int          n;
        sixel_word_t w;
        n = 0;
        if (run_active && mask == run_pat && int'(run_len) < MAX_COLUMNS) begin
            run_len = run_len + 13'd1;
        end else begin
            if (run_active) n += encode_run(run_pat, run_len);
            run_pat    = mask;
            run_len    = 13'd1;
            run_active = 1'b1;
        end
        if (last) begin
            if (run_pat != 6'd0) n += encode_run(run_pat, run_len);
            if (n == 0) begin
                w.ch       = 7'd0;
                w.has_char = 1'b0;
                w.row_end  = 1'b1;
                append_word(w);
            end else begin
                w = sixel_chars.pop_back();
                w.row_end = 1'b1;
                append_word(w);
            end
            run_pat    = 6'd0;
            run_len    = 13'd0;
            run_active = 1'b0;
        end
    endfunction

    function automatic void check_word();
        sixel_word_t w;
        if (sixel_chars.size() == 0) begin
            if (errors < 10)
                $display("%0t: unexpected word char=%0d valid=%0b end=%0b",
                         $realtime, m_out_char, m_char_valid, m_row_end);
            errors++;
            return;
        end
        w = sixel_chars.pop_front();
        if (m_out_char !== w.ch || m_char_valid !== w.has_char || m_row_end !== w.row_end) begin
            if (errors < 10)
                $display("%0t: mismatch exp char=%0d valid=%0b end=%0b %s=%0d valid=%0b end=%0b",
                         $realtime, w.ch, w.has_char, w.row_end, "got char",
                         m_out_char, m_char_valid, m_row_end);
            errors++;
        end
    endfunction

    initial begin
        errors = 0;
        repeat_threshold = THRESHOLD_AT_RESET;
        run_pat = '0;
        run_len = '0;
        run_active = 1'b0;
        fail_count = 0;
        chars_pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            repeat_threshold = THRESHOLD_AT_RESET;
            run_pat    = '0;
            run_len    = '0;
            run_active = 1'b0;
            sixel_chars.delete();
        end else begin
            if (cfg_wr_en) repeat_threshold = cfg_wr_data;
            if (s_valid && s_ready) encode_column(s_column_mask, s_last_column);
            if (m_valid && m_ready) check_word();
        end
        fail_count    <= errors;
        chars_pending <= sixel_chars.size();
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_COLUMNS = 4096;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF    = 20;
    localparam int COLUMN_GOAL = 450;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [5:0] s_column_mask = 6'd0;
    logic       s_last_column = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_out_char;
    logic       m_char_valid;
    logic       m_row_end;

    int  fail_count;
    int  chars_pending;
    bit  idle_on = 1'b1;
    int  m_hold = 0;
    int  quiet_cycles = 0;
    int  columns_sent = 0;

    always #2 aclk = ~aclk;

    sixel_row_run_length_encoder_unit #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_column_mask (s_column_mask),
        .s_last_column (s_last_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_char_valid  (m_char_valid),
        .m_row_end     (m_row_end)
    );

    srle_checker #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_column_mask (s_column_mask),
        .s_last_column (s_last_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_char_valid  (m_char_valid),
        .m_row_end     (m_row_end),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // output side back-pressure, one draw per accepted word
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_hold  <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                gap = idle_on ? $urandom_range(0, 19) : 0;
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    m_hold  <= gap;
                end
            end
        end else begin
            if (m_hold <= 1) m_ready <= 1'b1;
            m_hold <= m_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_column(input logic [5:0] mask, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_column_mask <= mask;
        s_last_column <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        columns_sent++;
    endtask

    task automatic send_run(input logic [5:0] pat, input int len, input logic close_row);
        for (int i = 0; i < len; i++) send_column(pat, close_row && (i == len - 1));
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_rows(input int goal);
        int stop_at;
        int nruns;
        int sel;
        int len;
        logic [5:0] pat;
        stop_at = columns_sent + goal;
        while (columns_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                nruns = $urandom_range(1, 6);
                for (int k = 0; k < nruns && columns_sent < stop_at; k++) begin
                    pat = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
                    sel = $urandom_range(0, 19);
                    if (sel < 12) len = $urandom_range(1, 6);
                    else if (sel < 18) len = $urandom_range(7, 15);
                    else len = $urandom_range(16, 120);
                    if (len > stop_at - columns_sent) len = stop_at - columns_sent;
                    send_run(pat, len, k == nruns - 1);
                end
            end else begin
                nruns = $urandom_range(1, 10);
                for (int k = 0; k < nruns && columns_sent < stop_at; k++)
                    send_column(6'($urandom_range(0, 63)), $urandom_range(0, 3) == 0);
            end
        end
        send_column(6'($urandom_range(0, 63)), 1'b1);
    endtask

    initial begin
        logic [7:0] thr_list[10];
        thr_list = '{8'd2, 8'd7, 8'd8, 8'd255, 8'd0, 8'd1, 8'd3, 8'd5, 8'd6, 8'd4};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset threshold of four
        send_column(6'd0, 1'b1);
        send_column(6'd63, 1'b1);
        send_run(6'd1, 4, 1'b1);
        send_run(6'd2, 3, 1'b0);
        send_column(6'd0, 1'b1);
        send_run(6'd0, 2, 1'b0);
        send_column(6'd5, 1'b1);
        set_threshold(8'd0);
        send_column(6'd7, 1'b1);
        set_threshold(8'd1);
        send_run(6'd9, 2, 1'b0);
        send_column(6'd10, 1'b1);
        set_threshold(8'd255);
        send_run(6'd3, 7, 1'b0);
        send_run(6'd4, 6, 1'b1);

        for (int ph = 0; ph < 11; ph++) begin
            if (ph < 10) set_threshold(thr_list[ph]);
            else set_threshold(8'($urandom_range(0, 255)));
            idle_on <= ($urandom_range(0, 3) != 0);
            send_random_rows(COLUMN_GOAL / 11);
        end

        idle_on <= 1'b1;
        wait_drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
